// ----- rtl/dprq_pkg.sv -----
package dprq_pkg;

    localparam int SLOT_COUNT_DEF = 10;
    localparam int SLOT_DEPTH_DEF = 5;

    localparam int TS_W  = 32;
    localparam int LAT_W = 25;
    localparam int LON_W = 26;
    localparam int CHAR_W = 7;
    localparam int TD_W  = 12;
    localparam int FOLD_W = 18;
    localparam int REC_W = TD_W + 2 * FOLD_W;
    localparam int DIGIT_W = 6;

    localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'h2f;
    localparam logic [CHAR_W-1:0] CHAR_STAR  = 7'h2a;

    // character source for one output request
    localparam logic [1:0] SEL_SLASH = 2'd0;
    localparam logic [1:0] SEL_STAR  = 2'd1;
    localparam logic [1:0] SEL_DIGIT = 2'd2;

    typedef struct packed {
        logic [LON_W-1:0] lon;
        logic [LAT_W-1:0] lat;
        logic [TS_W-1:0]  ts;
    } pos_t;

    typedef struct packed {
        logic       load_rec;
        logic       emit;
        logic [1:0] sel;
        logic       last;
    } emit_ctrl_t;

    function automatic logic [CHAR_W-1:0] b64_char(input logic [DIGIT_W-1:0] v);
        logic [CHAR_W-1:0] c;
        case (v) inside
            [6'd0:6'd25]:  c = 7'h41 + CHAR_W'(v);
            [6'd26:6'd51]: c = 7'h61 + CHAR_W'(v - 6'd26);
            [6'd52:6'd61]: c = 7'h30 + CHAR_W'(v - 6'd52);
            6'd62:         c = 7'h2b;
            default:       c = 7'h2f;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/dprq_pos_mem.sv -----
module dprq_pos_mem
    import dprq_pkg::*;
#(
    parameter int DEPTH = SLOT_COUNT_DEF * SLOT_DEPTH_DEF,
    parameter int AW    = $clog2(SLOT_COUNT_DEF * SLOT_DEPTH_DEF)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  pos_t          wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output pos_t          rdata
);

    pos_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/dprq_char_out.sv -----
module dprq_char_out
    import dprq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  emit_ctrl_t        ctrl,
    input  logic [REC_W-1:0]  rec,
    input  logic              out_ready,
    output logic              free,
    output logic              out_valid,
    output logic [CHAR_W-1:0] out_char,
    output logic              out_last
);

    logic [REC_W-1:0]  rec_reg, rec_next;
    logic              valid_reg, valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        rec_next   = rec_reg;
        valid_next = valid_reg && !out_ready;
        char_next  = char_reg;
        last_next  = last_reg;
        if (ctrl.load_rec)
        begin
            rec_next = rec;
        end
        if (ctrl.emit)
        begin
            valid_next = 1'b1;
            last_next  = ctrl.last;
            case (ctrl.sel)
                SEL_SLASH: char_next = CHAR_SLASH;
                SEL_STAR:  char_next = CHAR_STAR;
                default:
                begin
                    // take the top digit, shift the next one up
                    char_next = b64_char(rec_reg[REC_W-1 -: DIGIT_W]);
                    rec_next  = {rec_reg[REC_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg  <= rec_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

// ----- rtl/delayed_position_report_queue.sv -----
// Channel  Dir  Signals                       Contents
// s_       in   s_tvalid s_tready s_tdata     queue or send request
//               s_tuser                       operation (0 queue, 1 send)
// m_       out  m_tvalid m_tready m_tdata     one report character
//               m_tlast                       final character of a send
//
// A queue request writes the position to the position memory and updates
// the slot count and write index. A send on an empty slot only advances the
// head slot. A send on a slot holding n records drains it: per record a
// memory read and delta capture, then eight characters at one a cycle
// through the output register while it is not stalled, plus two prefix
// characters before the first record. Output stalls stretch the drain.
// Reset clears the slot counts, write indices and head slot; the position
// memory is not cleared, entries are read only after being written.
module delayed_position_report_queue
    import dprq_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int SLOT_DEPTH = SLOT_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // delay[3:0], timestamp[35:4], latitude[60:36], longitude[86:61], zero[87]
    input  logic [87:0] s_tdata,
    // operation[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // code_char[6:0], zero[7]
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    localparam int SW    = $clog2(SLOT_COUNT);
    localparam int DW    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int CW    = $clog2(SLOT_DEPTH + 1);
    localparam int IW    = CW + 1;
    localparam int DEPTH = SLOT_COUNT * SLOT_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUMW  = ((SW > 4) ? SW : 4) + 1;
    // worst case head + delay is SLOT_COUNT - 1 + 15
    localparam int MOD_STEPS = (SLOT_COUNT + 14) / SLOT_COUNT;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_PFX1  = 3'd2;
    localparam logic [2:0] ST_PFX2  = 3'd3;
    localparam logic [2:0] ST_CHARS = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic          first_reg, first_next;
    logic [2:0]    digit_reg, digit_next;
    pos_t          prev_reg, prev_next;
    logic [CW-1:0] cnt_reg  [SLOT_COUNT];
    logic [DW-1:0] widx_reg [SLOT_COUNT];

    // request fields
    logic          op;
    logic [3:0]    delay;
    pos_t          in_pos;
    logic          accept;

    assign op         = s_tuser;
    assign delay      = s_tdata[3:0];
    assign in_pos.ts  = s_tdata[35:4];
    assign in_pos.lat = s_tdata[60:36];
    assign in_pos.lon = s_tdata[86:61];
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;

    // target slot of a queue request: (head + delay) mod SLOT_COUNT
    logic [SUMW-1:0] tgt_sum;
    logic [SW-1:0]   tgt_slot;
    logic [DW-1:0]   tgt_w;
    logic [DW-1:0]   tgt_w_inc;

    always_comb
    begin
        tgt_sum = SUMW'(head_reg) + SUMW'(delay);
        for (int i = 0; i < MOD_STEPS; i++)
        begin
            if (tgt_sum >= SUMW'(SLOT_COUNT))
            begin
                tgt_sum = tgt_sum - SUMW'(SLOT_COUNT);
            end
        end
        tgt_slot  = tgt_sum[SW-1:0];
        tgt_w     = widx_reg[tgt_slot];
        tgt_w_inc = (IW'(tgt_w) + IW'(1) == IW'(SLOT_DEPTH)) ? '0 : DW'(tgt_w + 1'b1);
    end

    // oldest entry of the slot being drained, given the remaining count
    logic [SW-1:0] rd_slot;
    logic [CW-1:0] rd_n;
    logic [IW-1:0] rd_w;
    logic [IW-1:0] rd_idx;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            rd_slot = head_reg;
            rd_n    = cnt_reg[head_reg];
        end
        else
        begin
            rd_slot = slot_reg;
            rd_n    = cnt_reg[slot_reg] - 1'b1;
        end
        rd_w = IW'(widx_reg[rd_slot]);
        if (rd_w >= IW'(rd_n))
        begin
            rd_idx = rd_w - IW'(rd_n);
        end
        else
        begin
            rd_idx = rd_w + IW'(SLOT_DEPTH) - IW'(rd_n);
        end
        rd_addr = AW'(AW'(rd_slot) * SLOT_DEPTH + AW'(rd_idx));
        wr_addr = AW'(AW'(tgt_slot) * SLOT_DEPTH + AW'(tgt_w));
    end

    // position memory
    logic mem_we;
    logic mem_re;
    pos_t mem_rdata;

    dprq_pos_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wr_addr),
        .wdata (in_pos),
        .re    (mem_re),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    // deltas of the record just read against the position of the send request
    logic [TD_W-1:0]   td;
    logic [LAT_W:0]    lat_d;
    logic [LON_W:0]    lon_d;
    logic [REC_W-1:0]  rec;

    always_comb
    begin
        td    = mem_rdata.ts[TD_W-1:0] - prev_reg.ts[TD_W-1:0];
        lat_d = {mem_rdata.lat[LAT_W-1], mem_rdata.lat} - {prev_reg.lat[LAT_W-1], prev_reg.lat};
        lon_d = {mem_rdata.lon[LON_W-1], mem_rdata.lon} - {prev_reg.lon[LON_W-1], prev_reg.lon};
        // fold: sign on top, low 17 bits of the two's complement below
        rec   = {td, lat_d[LAT_W], lat_d[16:0], lon_d[LON_W], lon_d[16:0]};
    end

    // output register
    emit_ctrl_t ctrl;
    logic       out_free;
    logic [CHAR_W-1:0] out_char;

    dprq_char_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .rec       (rec),
        .out_ready (m_tready),
        .free      (out_free),
        .out_valid (m_tvalid),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {1'b0, out_char};

    // control
    logic          cnt_we;
    logic [SW-1:0] cnt_slot;
    logic [CW-1:0] cnt_val;
    logic          widx_we;
    logic [SW-1:0] head_inc;
    logic          last_rec;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        slot_next  = slot_reg;
        first_next = first_reg;
        digit_next = digit_reg;
        prev_next  = prev_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        cnt_we     = 1'b0;
        cnt_slot   = tgt_slot;
        cnt_val    = cnt_reg[tgt_slot];
        widx_we    = 1'b0;
        ctrl       = '0;
        head_inc   = (head_reg == SW'(SLOT_COUNT - 1)) ? '0 : head_reg + 1'b1;
        last_rec   = (cnt_reg[slot_reg] == CW'(1));

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!op)
                    begin
                        // store, overwrite oldest when full
                        mem_we  = 1'b1;
                        widx_we = 1'b1;
                        cnt_we  = 1'b1;
                        if (cnt_reg[tgt_slot] != CW'(SLOT_DEPTH))
                        begin
                            cnt_val = cnt_reg[tgt_slot] + 1'b1;
                        end
                    end
                    else if (cnt_reg[head_reg] == '0)
                    begin
                        head_next = head_inc;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        slot_next  = head_reg;
                        prev_next  = in_pos;
                        first_next = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                ctrl.load_rec = 1'b1;
                digit_next    = '0;
                state_next    = first_reg ? ST_PFX1 : ST_CHARS;
            end
            ST_PFX1:
            begin
                if (out_free)
                begin
                    ctrl.emit  = 1'b1;
                    ctrl.sel   = SEL_SLASH;
                    state_next = ST_PFX2;
                end
            end
            ST_PFX2:
            begin
                if (out_free)
                begin
                    ctrl.emit  = 1'b1;
                    ctrl.sel   = SEL_STAR;
                    first_next = 1'b0;
                    state_next = ST_CHARS;
                end
            end
            ST_CHARS:
            begin
                if (out_free)
                begin
                    ctrl.emit  = 1'b1;
                    ctrl.sel   = SEL_DIGIT;
                    ctrl.last  = (digit_reg == 3'd7) && last_rec;
                    digit_next = digit_reg + 1'b1;
                    if (digit_reg == 3'd7)
                    begin
                        // record done: drop it from the slot
                        cnt_we   = 1'b1;
                        cnt_slot = slot_reg;
                        cnt_val  = cnt_reg[slot_reg] - 1'b1;
                        if (last_rec)
                        begin
                            head_next  = (slot_reg == SW'(SLOT_COUNT - 1)) ? '0
                                                                          : slot_reg + 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            state_next = ST_LOAD;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            first_reg <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                cnt_reg[i]  <= '0;
                widx_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            first_reg <= first_next;
            if (cnt_we)
            begin
                cnt_reg[cnt_slot] <= cnt_val;
            end
            if (widx_we)
            begin
                widx_reg[tgt_slot] <= tgt_w_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        digit_reg <= digit_next;
        prev_reg  <= prev_next;
    end

endmodule
